>>> hw/rtl/breathing_led_brightness_core_defines.svh
// Assertion macros shared by the breathing LED brightness RTL.
`ifndef BREATHING_LED_BRIGHTNESS_CORE_DEFINES_SVH
`define BREATHING_LED_BRIGHTNESS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/blb_pkg.sv
// Shared types, constants and the wave table function of the breathing LED block.
package blb_pkg;

  // Default sizes
  localparam int PHASE_BITS_DEF  = 10;
  localparam int WAVE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [31:0] PERIOD_RST = 32'd2000;
  localparam logic [7:0]  MIN_RST    = 8'd0;
  localparam logic [7:0]  MAX_RST    = 8'd255;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_MIN    = 2'd1,
    REG_MAX    = 2'd2
  } blb_reg_e;

  // Fixed-point sine evaluation
  localparam int          QF  = 30;
  localparam logic [63:0] PIQ = 64'd3373259426;

  typedef struct packed {
    logic [7:0] min_level;
    logic [7:0] max_level;
  } blb_levels_t;

  typedef struct packed {
    logic full;
    logic empty;
  } blb_fifo_stat_t;

  // sin^2(pi * m / 2^pb) in Q1.wb, Horner series of sin(u)/u; elaboration only
  function automatic logic [63:0] wave_of(input int unsigned m, input int unsigned pb,
                                          input int unsigned wb);
    logic [63:0] one;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] sq;
    logic [63:0] w;
    one = 64'd1 << QF;
    u   = (PIQ * 64'(m)) >> pb;
    u2  = (u * u) >> QF;
    f   = one;
    t = ((u2 * f) >> QF) / 64'd210;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd156;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd110;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd72;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd42;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd20;
    f = (t >= one) ? 64'd0 : one - t;
    t = ((u2 * f) >> QF) / 64'd6;
    f = (t >= one) ? 64'd0 : one - t;
    s  = (u * f) >> QF;
    sq = s * s;
    w  = (sq + (64'd1 << (59 - wb))) >> (60 - wb);
    if (w > (64'd1 << wb)) begin
      w = 64'd1 << wb;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/blb_front.sv
// Front end: pipelined restoring divider giving the phase index, folded about the half cycle.
module blb_front import blb_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           period_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           time_ms_i,
  input  blb_fifo_stat_t        fifo_stat_i,
  output logic                  push_o,
  output logic [PHASE_BITS-1:0] phase_o
);

  // One quotient bit per stage over {time, PHASE_BITS zeros}
  localparam int DIV_W = 32 + PHASE_BITS;
  localparam int NSTG  = DIV_W;
  localparam logic [PHASE_BITS-1:0] HALF_K = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] ONE_K  = PHASE_BITS'(1);

  logic [31:0]           p_eff;
  logic                  adv;
  logic [NSTG-1:0]       v_q;
  logic [DIV_W-1:0]      num_q [NSTG-1];
  logic [31:0]           rem_q [NSTG-1];
  logic [PHASE_BITS-1:0] quo_q [NSTG];
  logic [PHASE_BITS-1:0] k;

  // Hold a zero period at one
  assign p_eff = (period_i == 32'd0) ? 32'd1 : period_i;

  // Advance the whole pipe unless the tail is blocked by a full queue
  assign adv        = !(v_q[NSTG-1] && fifo_stat_i.full);
  assign in_stall_o = !adv;
  assign push_o     = v_q[NSTG-1] && !fifo_stat_i.full;

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic                  v_in;
    logic [DIV_W-1:0]      num_in;
    logic [31:0]           rem_in;
    logic [PHASE_BITS-1:0] quo_in;
    logic [32:0]           trial;
    logic [32:0]           diff;
    logic                  ge;
    logic [31:0]           rem_d;
    logic [PHASE_BITS-1:0] quo_d;

    if (g == 0) begin : g_head
      assign v_in   = in_valid_i;
      assign num_in = {time_ms_i, {PHASE_BITS{1'b0}}};
      assign rem_in = 32'd0;
      assign quo_in = '0;
    end else begin : g_body
      assign v_in   = v_q[g-1];
      assign num_in = num_q[g-1];
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // Trial subtract of the period from the shifted partial remainder
    always_comb begin
      trial = {rem_in, num_in[DIV_W-1]};
      diff  = trial - {1'b0, p_eff};
      ge    = (trial >= {1'b0, p_eff});
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_in[PHASE_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (adv) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        quo_q[g] <= quo_d;
      end
    end

    if (g < NSTG - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[g] <= rem_d;
          num_q[g] <= {num_in[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  // Fold the phase about the half cycle: sin^2 is symmetric there
  assign k       = quo_q[NSTG-1];
  assign phase_o = (k > HALF_K) ? (~k + ONE_K) : k;

endmodule

>>> hw/rtl/blb_fifo.sv
// Short queue between the divider front end and the wave back end.
module blb_fifo import blb_pkg::*; #(
  parameter int WIDTH = PHASE_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output blb_fifo_stat_t   stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> hw/rtl/blb_back.sv
// Back end: wave table lookup, scaling between the two levels and the output register.
module blb_back import blb_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int WAVE_BITS  = WAVE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blb_levels_t           levels_i,
  input  blb_fifo_stat_t        fifo_stat_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            level_o
);

  localparam int WW        = WAVE_BITS + 1;
  localparam int PW        = WAVE_BITS + 9;
  localparam int ROM_DEPTH = (1 << (PHASE_BITS - 1)) + 1;

  logic [WW-1:0] rom [ROM_DEPTH];
  logic          en;
  logic          v1_q;
  logic [WW-1:0] w_q;
  logic          out_v_q;
  logic [7:0]    level_q, level_d;
  logic          up;
  logic [7:0]    absd;
  logic [PW-1:0] prod;
  logic [7:0]    q;

  // Constant wave table over the first half cycle
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign rom[g] = WW'(wave_of(g, PHASE_BITS, WAVE_BITS));
  end

  // Move both stages unless the result register is held by the receiver
  assign en    = !(out_v_q && out_stall_i);
  assign pop_o = en && !fifo_stat_i.empty;

  // Scale the wave by the level span, truncating toward zero
  always_comb begin
    up      = (levels_i.max_level >= levels_i.min_level);
    absd    = up ? (levels_i.max_level - levels_i.min_level)
                 : (levels_i.min_level - levels_i.max_level);
    prod    = PW'(w_q) * PW'(absd);
    q       = prod[WAVE_BITS+7:WAVE_BITS];
    level_d = up ? (levels_i.min_level + q) : (levels_i.min_level - q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= pop_o;
      out_v_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      w_q <= rom[phase_i];
    end
    if (en && v1_q) begin
      level_q <= level_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign level_o     = level_q;

endmodule

>>> hw/rtl/breathing_led_brightness_core.sv
// Top level of the breathing LED brightness block: register port, front, queue and back.
//
// A time stamp in milliseconds enters on the input channel (in_valid_i, in_stall_o,
// time_ms_i); the LED level for that instant leaves on the output channel
// (out_valid_o, out_stall_i, level_o). A transaction completes at a rising edge
// with valid high and stall low.
// One transaction per cycle is taken in steady flow. Each time stamp passes through
// the restoring divider, which resolves one quotient bit in each of its
// 32 + PHASE_BITS stages, then the queue, the table read and the result register.
// When the receiver stalls, the result register holds; the back end stops, the
// queue fills and only then does the divider stop and raise in_stall_o.
// Reset empties the pipe and the queue and loads period 2000 ms, minimum 0,
// maximum 255. Registers are written over the APB port (period at 0x0, minimum
// at 0x4, maximum at 0x8); the user must write them only while no transaction
// is in flight, and the block itself does not enforce this.
`include "breathing_led_brightness_core_defines.svh"

module breathing_led_brightness_core import blb_pkg::*; #(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int WAVE_BITS   = WAVE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // time stamp channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       time_ms_i,
  // level channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        level_o
);

  logic [31:0]           period_q;
  logic [7:0]            min_q;
  logic [7:0]            max_q;
  logic                  wr_en;
  blb_reg_e              reg_sel;
  blb_levels_t           levels;
  blb_fifo_stat_t        fifo_stat;
  logic                  push;
  logic                  pop;
  logic [PHASE_BITS-1:0] phase_front;
  logic [PHASE_BITS-1:0] phase_back;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = blb_reg_e'(paddr[3:2]);

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      min_q    <= MIN_RST;
      max_q    <= MAX_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PERIOD: period_q <= pwdata;
        REG_MIN:    min_q    <= pwdata[7:0];
        REG_MAX:    max_q    <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_PERIOD: prdata = period_q;
      REG_MIN:    prdata = {24'd0, min_q};
      REG_MAX:    prdata = {24'd0, max_q};
      default:    prdata = '0;
    endcase
  end

  assign levels.min_level = min_q;
  assign levels.max_level = max_q;

  blb_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .time_ms_i   (time_ms_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .phase_o     (phase_front)
  );

  blb_fifo #(
    .WIDTH (PHASE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (phase_front),
    .pop_i  (pop),
    .data_o (phase_back),
    .stat_o (fifo_stat)
  );

  blb_back #(
    .PHASE_BITS (PHASE_BITS),
    .WAVE_BITS  (WAVE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .levels_i    (levels),
    .fifo_stat_i (fifo_stat),
    .phase_i     (phase_back),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o)
  );

  // Queue bookkeeping and back-pressure
  `BLB_ASSERT_IMPL(a_no_push_full, push, !fifo_stat.full, "push into a full queue")
  `BLB_ASSERT_IMPL(a_no_pop_empty, pop, !fifo_stat.empty, "pop from an empty queue")
  `BLB_ASSERT_IMPL(a_stall_full, in_stall_o, fifo_stat.full, "input stalled with queue room")
  `BLB_ASSERT_NEXT(a_push_fills, push, !fifo_stat.empty, "queue empty after a push")

endmodule
